/* rtl/core/mbr_pkg.sv */
// ----------------------------------------------------------------------------
// mbr_pkg
// Shared codes and types for the MSB-first bit reader with sync hunt.
// ----------------------------------------------------------------------------
`default_nettype none

package mbr_pkg;

  // item kinds (in_tuser)
  localparam logic [1:0] ACT_PUSH = 2'd0;
  localparam logic [1:0] ACT_READ = 2'd1;
  localparam logic [1:0] ACT_HUNT = 2'd2;

  // result kinds (out_tuser)
  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_UNDERRUN = 2'd1;
  localparam logic [1:0] STS_SYNC     = 2'd2;
  localparam logic [1:0] STS_OVERFLOW = 2'd3;

  localparam int MaxReadBits = 32;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_HUNT = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

endpackage : mbr_pkg

`default_nettype wire

/* rtl/core/mbr_store.sv */
// ----------------------------------------------------------------------------
// mbr_store
// Circular byte store: one write port, one registered read port. A write to
// the address being read in the same cycle is forwarded to the read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mbr_store
  import mbr_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [7:0]               wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [7:0]               rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // write-first on an address match
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule : mbr_store

`default_nettype wire

/* rtl/core/msb_bit_reader_sync_hunt.sv */
// ----------------------------------------------------------------------------
// msb_bit_reader_sync_hunt
// MSB-first bit reader over a small circular byte store, with sync-word hunt.
// ----------------------------------------------------------------------------
// Each input transaction is a push (one stream byte), a read of 0..32 bits
// (first bit most significant, counts above 32 saturate) or the start of a
// sync hunt, which consumes bits until SYNC_ONES ones in a row are seen and
// then reports the byte offset where that run began. A hunt that runs out of
// buffered bits waits and resumes on later pushes; a read abandons it.
// A push stores one stream byte and runs the hunt scan if one is waiting;
// a read touches ceil((bit_offset + n) / 8) store bytes for n > 0, and a
// hunt scans one store byte per cycle. Overflow pushes, underflow and
// zero-bit reads go to the result without using the store. The byte store
// has a single read port and one byte comes out of it per cycle, which
// paces reads and hunts. Results pass through an output register, so the next
// transaction is accepted while a result waits for out_tready. The store
// needs no clearing after reset: only written bytes are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module msb_bit_reader_sync_hunt
  import mbr_pkg::*;
#(
  parameter int STORE_BYTES = 8,
  parameter int SYNC_ONES   = 12
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [7:0] in_byte, [13:8] bit_count, [15:14] zero
  input  wire logic [1:0]  in_tuser,   // [1:0] action
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [63:0] out_tdata,  // [31:0] value, [63:32] sync_offset
  output logic      [1:0]  out_tuser   // [1:0] status
);

  localparam int StoreBits = STORE_BYTES * 8;
  localparam int IdxW      = $clog2(STORE_BYTES);
  localparam int FillW     = $clog2(StoreBits + 1);
  localparam int RunW      = $clog2(SYNC_ONES + 1);

  // input fields
  logic [1:0] in_action;
  logic [7:0] in_byte;
  logic [5:0] in_bit_count;
  assign in_action    = in_tuser;
  assign in_byte      = in_tdata[7:0];
  assign in_bit_count = in_tdata[13:8];

  // control state
  state_t            state_r, state_nxt;
  logic [IdxW-1:0]   rd_idx_r, rd_idx_nxt;     // store byte of next unread bit
  logic [2:0]        bit_off_r, bit_off_nxt;   // bit within that byte, MSB = 0
  logic [FillW-1:0]  fill_r, fill_nxt;
  logic              hunt_r, hunt_nxt;
  logic [RunW-1:0]   run_r, run_nxt;
  logic [31:0]       cons_r, cons_nxt;         // bits consumed, wraps
  logic [5:0]        remain_r, remain_nxt;     // bits left in a read
  logic              out_tvalid_r, out_tvalid_nxt;

  // payload
  logic [31:0]       res_value_r, res_value_nxt;
  logic [1:0]        res_status_r, res_status_nxt;
  logic [31:0]       out_value_r, out_value_nxt;
  logic [31:0]       out_offset_r, out_offset_nxt;
  logic [1:0]        out_status_r, out_status_nxt;

  // store port
  logic              st_wr_en;
  logic [IdxW-1:0]   st_wr_addr;
  logic [7:0]        st_rd_data;

  mbr_store #(
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (in_byte),
    .rd_addr (rd_idx_nxt),    // data for the current byte is always ready
    .rd_data (st_rd_data)
  );

  // occupancy: bytes holding unread bits, and the slot after them
  logic [FillW+1:0] used_bytes;
  logic [IdxW:0]    wr_sum;
  logic             store_full;
  assign used_bytes = ((FillW+2)'(bit_off_r) + (FillW+2)'(fill_r) + (FillW+2)'(7)) >> 3;
  assign store_full = used_bytes >= (FillW+2)'(STORE_BYTES);
  assign wr_sum     = (IdxW+1)'(rd_idx_r) + used_bytes[IdxW:0];
  assign st_wr_addr = (wr_sum >= (IdxW+1)'(STORE_BYTES))
                    ? IdxW'(wr_sum - (IdxW+1)'(STORE_BYTES)) : wr_sum[IdxW-1:0];

  logic       in_fire;
  logic       out_free;
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign st_wr_en  = in_fire && (in_action == ACT_PUSH) && !store_full;

  // saturated read count
  logic [5:0] rd_count;
  assign rd_count = (in_bit_count > 6'(MaxReadBits)) ? 6'(MaxReadBits) : in_bit_count;

  // bits left in the current byte
  logic [3:0] byte_left;
  assign byte_left = 4'd8 - {1'b0, bit_off_r};

  // read step: take up to the rest of the current byte
  logic [3:0] rd_take;
  logic [7:0] rd_shifted;
  logic [7:0] rd_field;
  assign rd_take    = ({2'b00, byte_left} < remain_r) ? byte_left : remain_r[3:0];
  assign rd_shifted = st_rd_data << bit_off_r;
  assign rd_field   = rd_shifted >> (4'd8 - rd_take);

  // hunt step: scan buffered bits of the current byte, stop on sync
  logic [3:0]      hunt_lim;
  logic [3:0]      hunt_cnt;
  logic [RunW-1:0] hunt_run;
  logic            hunt_found;
  always_comb begin
    hunt_lim   = (fill_r < FillW'(byte_left)) ? 4'({1'b0, bit_off_r}) + 4'(fill_r)
                                              : 4'd8;
    hunt_cnt   = 4'd0;
    hunt_run   = run_r;
    hunt_found = 1'b0;
    for (int j = 0; j < 8; j++) begin
      if (!hunt_found && (4'(j) >= {1'b0, bit_off_r}) && (4'(j) < hunt_lim)) begin
        if (st_rd_data[3'(7 - j)]) begin
          hunt_run = hunt_run + RunW'(1);
        end else begin
          hunt_run = '0;
        end
        hunt_cnt = hunt_cnt + 4'd1;
        if (hunt_run >= RunW'(SYNC_ONES)) begin
          hunt_found = 1'b1;
        end
      end
    end
  end

  // position advance shared by read and hunt steps
  logic [3:0] adv;
  logic [3:0] off_sum;
  always_comb begin
    adv = 4'd0;
    case (state_r)
      ST_READ: adv = rd_take;
      ST_HUNT: adv = hunt_cnt;
      default: adv = 4'd0;
    endcase
    off_sum = {1'b0, bit_off_r} + adv;
  end

  logic [31:0] sync_pos;
  assign sync_pos = cons_r - 32'(SYNC_ONES);

  always_comb begin
    state_nxt      = state_r;
    rd_idx_nxt     = rd_idx_r;
    bit_off_nxt    = bit_off_r;
    fill_nxt       = fill_r;
    hunt_nxt       = hunt_r;
    run_nxt        = run_r;
    cons_nxt       = cons_r;
    remain_nxt     = remain_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_value_nxt  = out_value_r;
    out_offset_nxt = out_offset_r;
    out_status_nxt = out_status_r;

    // consume the bits taken by a read or hunt step
    if ((state_r == ST_READ) || (state_r == ST_HUNT)) begin
      fill_nxt = fill_r - FillW'(adv);
      cons_nxt = cons_r + 32'(adv);
      if (off_sum == 4'd8) begin
        bit_off_nxt = 3'd0;
        rd_idx_nxt  = (rd_idx_r == IdxW'(STORE_BYTES - 1)) ? '0 : rd_idx_r + IdxW'(1);
      end else begin
        bit_off_nxt = off_sum[2:0];
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_action)
            ACT_PUSH: begin
              if (store_full) begin
                res_value_nxt  = '0;
                res_status_nxt = STS_OVERFLOW;
                state_nxt      = ST_DONE;
              end else begin
                fill_nxt = fill_r + FillW'(8);
                if (hunt_r) begin
                  state_nxt = ST_HUNT;
                end
              end
            end
            ACT_READ: begin
              hunt_nxt      = 1'b0;
              run_nxt       = '0;
              res_value_nxt = '0;
              if (fill_r < FillW'(rd_count)) begin
                res_status_nxt = STS_UNDERRUN;
                state_nxt      = ST_DONE;
              end else if (rd_count == 6'd0) begin
                res_status_nxt = STS_OK;
                state_nxt      = ST_DONE;
              end else begin
                res_status_nxt = STS_OK;
                remain_nxt     = rd_count;
                state_nxt      = ST_READ;
              end
            end
            ACT_HUNT: begin
              hunt_nxt = 1'b1;
              run_nxt  = '0;
              if (fill_r != '0) begin
                state_nxt = ST_HUNT;
              end
            end
            default: begin
              state_nxt = ST_IDLE;   // unused kind: dropped
            end
          endcase
        end
      end
      ST_READ: begin
        res_value_nxt = (res_value_r << rd_take) | {24'd0, rd_field};
        remain_nxt    = remain_r - {2'b00, rd_take};
        if (remain_r == {2'b00, rd_take}) begin
          state_nxt = ST_DONE;
        end
      end
      ST_HUNT: begin
        if (hunt_found) begin
          hunt_nxt       = 1'b0;
          run_nxt        = '0;
          res_value_nxt  = '0;
          res_status_nxt = STS_SYNC;
          state_nxt      = ST_DONE;
        end else begin
          run_nxt = hunt_run;
          if (fill_r == FillW'(hunt_cnt)) begin
            state_nxt = ST_IDLE;     // dry: hunt waits for pushes
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_value_nxt  = res_value_r;
          out_status_nxt = res_status_r;
          out_offset_nxt = (res_status_r == STS_SYNC) ? {3'b000, sync_pos[31:3]} : '0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rd_idx_r     <= '0;
      bit_off_r    <= '0;
      fill_r       <= '0;
      hunt_r       <= 1'b0;
      run_r        <= '0;
      cons_r       <= '0;
      remain_r     <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rd_idx_r     <= rd_idx_nxt;
      bit_off_r    <= bit_off_nxt;
      fill_r       <= fill_nxt;
      hunt_r       <= hunt_nxt;
      run_r        <= run_nxt;
      cons_r       <= cons_nxt;
      remain_r     <= remain_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    out_value_r  <= out_value_nxt;
    out_offset_r <= out_offset_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_offset_r, out_value_r};
  assign out_tuser  = out_status_r;

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FillW'(StoreBits))
    else $error("buffered bit count exceeds store size");

  a_read_covered: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> ((remain_r != 6'd0) && (fill_r >= FillW'(remain_r))))
    else $error("read in progress without enough buffered bits");

  a_hunt_has_bits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HUNT) |-> (hunt_r && (fill_r != '0)))
    else $error("hunt scan with nothing buffered or hunt inactive");

  a_sync_ends_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DONE) && (res_status_r == STS_SYNC)) |-> (!hunt_r && (run_r == '0)))
    else $error("sync reported while hunt still active");

  a_run_below_sync: assert property (@(posedge clk) disable iff (!rst_n)
    run_r < RunW'(SYNC_ONES))
    else $error("ones run reached sync length without a result");

endmodule : msb_bit_reader_sync_hunt

`default_nettype wire
